[src/slr_pkg.sv]
// Shared types and constants for the stereo linear resampler.
package slr_pkg;

   localparam int FRAC_WIDTH  = 16;
   localparam int SAMPLE_W    = 16;
   localparam int BASE_W      = 21;
   localparam int ADJ_W       = 18;
   localparam int ADJ_FRAC    = 16;
   localparam int STEP_W      = BASE_W + 1;
   localparam int PHASE_W     = ((FRAC_WIDTH + 1 > STEP_W) ? FRAC_WIDTH + 1 : STEP_W) + 1;
   localparam int MAX_RESULTS = 64;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [BASE_W-1:0]  BASE_STEP_RESET   = BASE_W'(65536);
   localparam logic [PHASE_W-1:0] PHASE_ONE         = PHASE_W'(1) << FRAC_WIDTH;
   localparam logic               CSR_IDX_BASE_STEP = 1'b0;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type              prev;
      sample_type              cur;
      logic [FRAC_WIDTH-1:0]   frac;
   } lane_in_type;

endpackage

[src/slr_step.sv]
// Step size unit: base step times rate trim, registered, then clamped and registered.
module slr_step
   import slr_pkg::*;
(
   input  logic                clock,
   input  logic [BASE_W-1:0]   base_step,
   input  logic [ADJ_W-1:0]    rate_adjust,
   output logic [STEP_W-1:0]   step
);

   localparam int PROD_W   = BASE_W + ADJ_W;
   localparam int SCALED_W = PROD_W - ADJ_FRAC;

   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [SCALED_W-1:0] scaled;
   logic [SCALED_W-1:0] lo_bound;
   logic [SCALED_W-1:0] hi_bound;
   logic [SCALED_W-1:0] clamped;

   assign prod_in  = PROD_W'(base_step) * PROD_W'(rate_adjust);
   assign scaled   = prod_ff[PROD_W-1:ADJ_FRAC];
   assign lo_bound = SCALED_W'(base_step >> 1);
   assign hi_bound = SCALED_W'({base_step, 1'b0});

   always_comb begin
      clamped = scaled;
      if (clamped < lo_bound) begin
         clamped = lo_bound;
      end
      if (clamped > hi_bound) begin
         clamped = hi_bound;
      end
      step_in = clamped[STEP_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      step_ff <= step_in;
   end

   assign step = step_ff;

endmodule

[src/slr_lane.sv]
// One channel lane: interpolates between the previous and current sample at a phase fraction.
module slr_lane
   import slr_pkg::*;
(
   input  lane_in_type lane_in,
   output sample_type  sample_out
);

   localparam int PROD_W = SAMPLE_W + FRAC_WIDTH + 2;

   logic signed [SAMPLE_W:0]     prev_ext;
   logic signed [SAMPLE_W:0]     cur_ext;
   logic signed [SAMPLE_W:0]     diff;
   logic signed [FRAC_WIDTH:0]   frac_s;
   logic signed [PROD_W-1:0]     prod;
   logic signed [PROD_W-1:0]     shifted;
   logic signed [SAMPLE_W:0]     delta;
   logic signed [SAMPLE_W:0]     sum;

   always_comb begin
      prev_ext = {lane_in.prev[SAMPLE_W-1], lane_in.prev};
      cur_ext  = {lane_in.cur[SAMPLE_W-1], lane_in.cur};
      diff     = cur_ext - prev_ext;
      frac_s   = $signed({1'b0, lane_in.frac});
      // The arithmetic shift floors towards minus infinity, which matches the
      // rounding for both positive and negative differences.
      prod     = PROD_W'(diff) * PROD_W'(frac_s);
      shifted  = prod >>> FRAC_WIDTH;
      delta    = shifted[SAMPLE_W:0];
      sum      = prev_ext + delta;
   end

   assign sample_out = sum[SAMPLE_W-1:0];

endmodule

[src/stereo_linear_resampler.sv]
// Top level of the stereo linear-interpolation sample rate converter.
//
//  Group   Direction  Contents (lowest bit first)
//  req_    in         tdata: in_left[15:0], in_right[31:16], rate_adjust[49:32], zero pad
//  rsp_    out        tdata: out_left[15:0], out_right[31:16]; tlast: run_last
//  csr_    in/out     APB register port, base_step at byte address 0
//
// A frame that only primes the converter is accepted, passes the step multiplier and
// the clamp, and returns to idle. A later frame is accepted, passes the step multiplier
// and the clamp, has its results produced in turn by the shared pair of lanes while
// results are taken at once, and is then retired. Reset is synchronous and active
// high; it clears the phase, the primed flag and the output valid flag and restores
// base_step to 65536. A stalled result holds in the output register and the sequencer
// waits; a new frame is taken only once the previous one has been retired.
module stereo_linear_resampler
   import slr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [55:0]             req_tdata,   // in_left, in_right, rate_adjust, pad

   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,   // out_left, out_right
   output logic                    rsp_tlast,   // run_last

   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_CLAMP,
      S_RUN
   } state_type;

   state_type            state_ff, state_in;
   logic [BASE_W-1:0]    base_step_ff, base_step_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 primed_ff, primed_in;
   sample_type           prev_l_ff, prev_l_in;
   sample_type           prev_r_ff, prev_r_in;
   sample_type           cur_l_ff, cur_l_in;
   sample_type           cur_r_ff, cur_r_in;
   logic [ADJ_W-1:0]     adj_ff, adj_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sample_type           out_l_ff, out_l_in;
   sample_type           out_r_ff, out_r_in;
   logic                 out_last_ff, out_last_in;

   logic [STEP_W-1:0]    step;
   logic [PHASE_W-1:0]   phase_sum;
   lane_in_type          lane_l_in, lane_r_in;
   sample_type           lane_l_out, lane_r_out;
   logic                 csr_wr;
   logic                 csr_idx;
   logic                 emit_ok;
   logic                 out_free;
   logic                 rsp_load;

   // Step size from the current trim; valid from the first run cycle onwards.
   slr_step u_step (
      .clock       (clock),
      .base_step   (base_step_ff),
      .rate_adjust (adj_ff),
      .step        (step)
   );

   // Two lanes, one per channel, share the phase fraction.
   assign lane_l_in = '{prev: prev_l_ff, cur: cur_l_ff, frac: phase_ff[FRAC_WIDTH-1:0]};
   assign lane_r_in = '{prev: prev_r_ff, cur: cur_r_ff, frac: phase_ff[FRAC_WIDTH-1:0]};

   slr_lane u_lane_l (
      .lane_in    (lane_l_in),
      .sample_out (lane_l_out)
   );

   slr_lane u_lane_r (
      .lane_in    (lane_r_in),
      .sample_out (lane_r_out)
   );

   // Register port. Word addressing: the low two address bits are ignored.
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_idx == CSR_IDX_BASE_STEP) ?
                       CSR_DATA_W'(base_step_ff) : '0;

   // A result may be produced while the phase is below one and the per-frame limit
   // has not been reached.
   assign emit_ok   = (phase_ff < PHASE_ONE) && (cnt_ff < CNT_W'(MAX_RESULTS));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign phase_sum = phase_ff + PHASE_W'(step);
   assign rsp_load  = (state_ff == S_RUN) && emit_ok && out_free;

   always_comb begin
      state_in     = state_ff;
      base_step_in = base_step_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      primed_in    = primed_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      cur_l_in     = cur_l_ff;
      cur_r_in     = cur_r_ff;
      adj_in       = adj_ff;
      rsp_valid_in = rsp_valid_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      out_last_in  = out_last_ff;

      if (csr_wr && (csr_idx == CSR_IDX_BASE_STEP)) begin
         base_step_in = csr_pwdata[BASE_W-1:0];
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cur_l_in = req_tdata[15:0];
               cur_r_in = req_tdata[31:16];
               adj_in   = req_tdata[49:32];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            if (!primed_ff) begin
               // The first frame after reset only becomes the previous frame.
               prev_l_in = cur_l_ff;
               prev_r_in = cur_r_ff;
               primed_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               cnt_in   = '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (emit_ok) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  out_l_in     = lane_l_out;
                  out_r_in     = lane_r_out;
                  out_last_in  = (phase_sum >= PHASE_ONE) ||
                                 (cnt_ff == CNT_W'(MAX_RESULTS - 1));
                  phase_in     = phase_sum;
                  cnt_in       = cnt_ff + CNT_W'(1);
               end
            end else begin
               // Retire the frame. When the result limit cut the run short the phase
               // restarts from zero.
               phase_in  = (phase_ff >= PHASE_ONE) ? (phase_ff - PHASE_ONE) : '0;
               prev_l_in = cur_l_ff;
               prev_r_in = cur_r_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_step_ff <= BASE_STEP_RESET;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         primed_ff    <= 1'b0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_step_ff <= base_step_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         primed_ff    <= primed_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_l_ff    <= cur_l_in;
      cur_r_ff    <= cur_r_in;
      adj_ff      <= adj_in;
      out_l_ff    <= out_l_in;
      out_r_ff    <= out_r_in;
      out_last_ff <= out_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_r_ff, out_l_ff};
   assign rsp_tlast  = out_last_ff;

   // A frame is worked on alone: after a transaction is accepted the input stays closed.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while a frame was still in progress");

   // The per-frame result count never passes the limit.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result count beyond the per-frame limit");

   // A new result is only loaded when the held one has gone or is being taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten while a result was held");

   // A run cut short by the result limit retires to idle with the phase cleared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && !emit_ok && phase_ff < PHASE_ONE)
      |=> (state_ff == S_IDLE && phase_ff == '0))
      else $error("frame retired with an inconsistent phase");

endmodule

[sim/tb_stereo_linear_resampler.sv]
// Self-checking testbench for the stereo linear resampler with a scoreboard.
`timescale 1ns / 100ps

module tb_stereo_linear_resampler;
   import slr_pkg::*;

   // One interpolated output frame as the block should present it.
   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       last;
   } stereo_out_type;

   localparam longint unsigned UNITY_PHASE = 64'(1) << FRAC_WIDTH;
   localparam int              LONG_HOLD   = 400;   // receiver hold-off, in cycles
   localparam int              HOLD_AT     = 60;    // result count that triggers it
   localparam int              SETTLE      = 12;    // cycles covering a frame's tail latency

   // Clock and reset. Every input of the block starts at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata   = '0;   // in_left, in_right, rate_adjust, pad
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [31:0]           rsp_tdata;          // out_left, out_right
   logic                  rsp_tlast;          // run_last
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   stereo_linear_resampler DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Frames waiting to be offered, and output frames the converter still owes us.
   logic [55:0]     frames_to_send[$];
   stereo_out_type  out_frames_due[$];
   int unsigned     mismatches = 0;

   // Our own copy of the converter's state and its base_step register.
   logic [BASE_W-1:0] step_base = BASE_STEP_RESET;
   longint unsigned   acc_phase = 0;
   sample_type        last_left = '0;
   sample_type        last_right = '0;
   bit                have_last = 1'b0;

   // Idle lengths: mostly nothing or a few cycles, now and then a long gap, and
   // occasionally a run of back-to-back transactions with no idling at all.
   function automatic int idle_len(inout int run);
      int r;
      if (run > 0) begin
         run--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
         run = $urandom_range(15, 40);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [55:0] pack_frame(sample_type l, sample_type r,
                                              logic [ADJ_W-1:0] adj);
      return {6'b0, adj, r, l};
   endfunction

   // Linear blend a + floor((b - a) * frac / 2^FRAC_WIDTH). The arithmetic shift of a
   // signed product rounds towards minus infinity, which is exactly the floor we want.
   function automatic sample_type blend(sample_type a, sample_type b, longint unsigned frac);
      longint diff;
      diff = longint'(b) - longint'(a);
      return sample_type'(longint'(a) + ((diff * longint'(frac)) >>> FRAC_WIDTH));
   endfunction

   // Advances our copy of the converter by one accepted frame and queues the output
   // frames it must produce, in order, with run_last on the final one.
   function automatic void resample_frame(logic [55:0] frame);
      sample_type        cur_l, cur_r;
      logic [ADJ_W-1:0]  adj;
      longint unsigned   step, lo, hi;
      int                n;
      stereo_out_type    f;
      cur_l = frame[15:0];
      cur_r = frame[31:16];
      adj   = frame[32 +: ADJ_W];
      step  = (64'(step_base) * 64'(adj)) >> ADJ_FRAC;
      lo    = 64'(step_base) >> 1;
      hi    = 64'(step_base) << 1;
      if (step < lo) step = lo;
      if (step > hi) step = hi;
      if (!have_last) begin
         // The very first frame only primes the history; phase is left alone.
         last_left  = cur_l;
         last_right = cur_r;
         have_last  = 1'b1;
         return;
      end
      n = 0;
      while (acc_phase < UNITY_PHASE && n < MAX_RESULTS) begin
         f.left  = blend(last_left, cur_l, acc_phase);
         f.right = blend(last_right, cur_r, acc_phase);
         acc_phase += step;
         n++;
         f.last = !(acc_phase < UNITY_PHASE && n < MAX_RESULTS);
         out_frames_due.push_back(f);
      end
      // Hitting the result cap with the phase still short of one clears the phase.
      if (acc_phase >= UNITY_PHASE) acc_phase -= UNITY_PHASE;
      else acc_phase = 0;
      last_left  = cur_l;
      last_right = cur_r;
   endfunction

   // Random frames: mostly full-range samples with a trim near unity, plus sample
   // extremes, quiet signals and the full trim range including its end points.
   function automatic logic [55:0] random_frame();
      sample_type       l, r;
      logic [ADJ_W-1:0] adj;
      int               pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         l = $urandom_range(0, 1) ? sample_type'(32767) : sample_type'(-32768);
         r = $urandom_range(0, 1) ? sample_type'(32767) : sample_type'(-32768);
      end else if (pick == 1) begin
         l = sample_type'(int'($urandom_range(0, 64)) - 32);
         r = sample_type'(int'($urandom_range(0, 64)) - 32);
      end else begin
         l = sample_type'($urandom());
         r = sample_type'($urandom());
      end
      pick = $urandom_range(0, 19);
      if (pick < 10)      adj = ADJ_W'($urandom_range(49152, 81920));
      else if (pick < 15) adj = ADJ_W'($urandom_range(0, 262143));
      else if (pick < 18) adj = ADJ_W'($urandom_range(0, 32768));
      else begin
         case ($urandom_range(0, 3))
            0:       adj = '0;
            1:       adj = '1;
            2:       adj = ADJ_W'(131072);
            default: adj = ADJ_W'(65536);
         endcase
      end
      return pack_frame(l, r, adj);
   endfunction

   // Sender. Holds a frame until its transaction completes, feeds the accepted
   // frame to the predictor, then inserts a random idle gap before the next one.
   int req_gap = 0;
   int req_run = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) resample_frame(req_tdata);
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (frames_to_send.size() > 0) begin
            req_tdata  <= frames_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_gap = idle_len(req_run);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver. Checks each result transaction against the oldest expected frame
   // and then stalls for a random number of cycles. Once, after HOLD_AT results,
   // it takes the long LONG_HOLD hold-off so that the output register and then the
   // input side of the block back up while the sender keeps offering frames.
   int             rsp_stall = 0;
   int             rsp_run = 0;
   int unsigned    results_seen = 0;
   stereo_out_type want;
   sample_type     got_left, got_right;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_left  = rsp_tdata[15:0];
            got_right = rsp_tdata[31:16];
            if (out_frames_due.size() == 0) begin
               $error("result with nothing expected: out_left %0d out_right %0d run_last %0b",
                      got_left, got_right, rsp_tlast);
               mismatches++;
            end else begin
               want = out_frames_due.pop_front();
               if (got_left !== want.left) begin
                  $error("out_left: expected %0d, got %0d", want.left, got_left);
                  mismatches++;
               end
               if (got_right !== want.right) begin
                  $error("out_right: expected %0d, got %0d", want.right, got_right);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("run_last: expected %0b, got %0b", want.last, rsp_tlast);
                  mismatches++;
               end
            end
            results_seen++;
            rsp_stall = (results_seen == HOLD_AT) ? LONG_HOLD : idle_len(rsp_run);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Waits, sampling away from the active edge, until every queued frame has been
   // taken and every expected result has arrived, then lets the block finish off
   // any frame that produces no result.
   task automatic drain();
      while (frames_to_send.size() != 0 || req_tvalid || out_frames_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Register write while the block is idle: a setup cycle and then an access
   // cycle; the register takes the value at the edge that ends the access cycle.
   task automatic set_base_step(logic [BASE_W-1:0] value);
      drain();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * CSR_IDX_BASE_STEP);
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      step_base = value;
   endtask

   task automatic queue_random(int count);
      repeat (count) frames_to_send.push_back(random_frame());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the reset value of base_step. The first only primes
      // the history. A zero trim clamps the step to half and gives two outputs,
      // interpolating halfway between full-scale opposites; the largest trim
      // clamps to twice the base, so the following frame enters with the phase
      // already at one and produces nothing.
      frames_to_send.push_back(pack_frame(32767, -32768, 18'd65536));
      frames_to_send.push_back(pack_frame(-32768, 32767, 18'd0));
      frames_to_send.push_back(pack_frame(32767, -32768, 18'd0));
      frames_to_send.push_back(pack_frame(0, 0, 18'h3FFFF));
      frames_to_send.push_back(pack_frame(123, -456, 18'd65536));
      frames_to_send.push_back(pack_frame(-1, 1, 18'd1));
      frames_to_send.push_back(pack_frame(100, -100, 18'd98304));
      frames_to_send.push_back(pack_frame(-32768, -32768, 18'd40000));
      frames_to_send.push_back(pack_frame(16'sh5555, 16'shAAAA, 18'h2AAAA));
      frames_to_send.push_back(pack_frame(16'shAAAA, 16'sh5555, 18'h15555));
      frames_to_send.push_back(pack_frame(32767, 32767, 18'd131072));
      frames_to_send.push_back(pack_frame(-32767, 1, 18'd32767));
      frames_to_send.push_back(pack_frame(7, -7, 18'd65535));
      frames_to_send.push_back(pack_frame(0, -32768, 18'd24576));
      frames_to_send.push_back(pack_frame(-32768, 0, 18'd24576));
      frames_to_send.push_back(pack_frame(1, -1, 18'd81920));
      frames_to_send.push_back(pack_frame(0, 0, 18'd65536));

      // Upsampling by about 1.6. The long receiver hold-off falls early in here,
      // and half way through the sender stops until everything has come back.
      set_base_step(BASE_W'(40000));
      queue_random(75);
      drain();
      queue_random(75);

      // Smallest base step in range: a zero trim gives up to the result cap.
      set_base_step(BASE_W'(2048));
      frames_to_send.push_back(pack_frame(-32768, 32767, 18'd0));
      queue_random(7);

      // Largest base step in range: most frames produce nothing.
      set_base_step(BASE_W'(1048576));
      queue_random(70);

      // All ones in the register: the widest step the block can see.
      set_base_step('1);
      queue_random(25);

      // Small steps, a zero step among them; where a step cannot reach one within the
      // cap, the remaining outputs are dropped and the phase is cleared.
      set_base_step('0);
      queue_random(3);
      set_base_step(BASE_W'(1000));
      queue_random(3);

      // Back to one to one, then a mild downsample.
      set_base_step(BASE_STEP_RESET);
      queue_random(70);
      set_base_step(BASE_W'(90000));
      queue_random(60);

      drain();
      if (mismatches == 0 && out_frames_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #(100_000_000);
      $display("== FAIL ==");
      $finish;
   end

endmodule
